// File: rtl/rrpt_pkg.sv
// Shared constants and types for the rounded rectangle point test.
// No dependencies; imported by the top level rounded_rect_point_test.
package rrpt_pkg;

   // Default coordinate width in bits (two's complement fixed point).
   localparam int COORD_WIDTH_DEF = 16;

   // Configuration port index width; indexes past the last register are dropped.
   localparam int CSR_INDEX_WIDTH = 4;

   // Result word: inside_res in bit 0, padded to one byte.
   localparam int RSP_DATA_WIDTH = 8;

   // Number of rounded corners.
   localparam int NUM_CORNERS = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RECT_LEFT           = 4'd0,
      CSR_RECT_TOP            = 4'd1,
      CSR_RECT_RIGHT          = 4'd2,
      CSR_RECT_BOTTOM         = 4'd3,
      CSR_RADIUS_TOP_LEFT     = 4'd4,
      CSR_RADIUS_TOP_RIGHT    = 4'd5,
      CSR_RADIUS_BOTTOM_LEFT  = 4'd6,
      CSR_RADIUS_BOTTOM_RIGHT = 4'd7
   } csr_index_type;

   // Corner slots, in the order in which they are checked.
   typedef enum logic [1:0] {
      CORNER_TOP_LEFT     = 2'd0,
      CORNER_TOP_RIGHT    = 2'd1,
      CORNER_BOTTOM_LEFT  = 2'd2,
      CORNER_BOTTOM_RIGHT = 2'd3
   } corner_type;

endpackage

// File: rtl/rounded_rect_point_test.sv
// Rounded rectangle point test: pipelined containment check, one point per cycle when not stalled.
// Depends on rrpt_pkg for the register index codes, corner slots and widths.
//
// Usage
//   req_* : input stream, one point per word. tdata = {point_y, point_x}, point_x in the
//           low COORD_WIDTH bits, zero padded to whole bytes.
//   rsp_* : result stream, one word per point, in order. tdata bit 0 = inside_res,
//           1 when the point lies inside: strictly within the edges, on or within the arcs.
//   csr_* : register writes (index, data). Write only while no point is in flight.
//           Writes are always taken (csr_ready is tied high).
// Pipeline: input register, then corner select, squaring and the compare, each ending in
//   a register; rsp_tvalid is driven from the compare stage's output register.
// Throughput: one point per clock while rsp_tready holds and no register write is
//   pending; the pipeline stages hand over in the same cycle. req_tready is low during
//   a register write and in the cycle after it, while the clamped radii and arc
//   centres are recomputed into their registers.
// Reset: synchronous, active high; clears every configuration register to zero (an
//   empty rectangle, so every point reports outside) and empties the pipeline.
// Stall: each stage holds while the next one is full and stalled, so bubbles are squeezed
//   out; req_tready falls once every stage holds a word or csr_valid or settle_ff is high.
module rounded_rect_point_test
   import rrpt_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Input stream
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // [COORD_WIDTH-1:0] point_x, [2*COORD_WIDTH-1:COORD_WIDTH] point_y, zero pad above
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   // Result stream
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // [0] inside_res, zero pad above
   output logic [RSP_DATA_WIDTH-1:0]                rsp_tdata,
   // Register write port
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]               csr_index,
   input  logic [COORD_WIDTH-1:0]                   csr_data
);

   localparam int CW = COORD_WIDTH;
   localparam int RW = COORD_WIDTH - 1;       // radius width
   localparam int SW = 2 * (COORD_WIDTH - 1); // square width

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic signed [CW-1:0] rect_left_ff, rect_top_ff, rect_right_ff, rect_bottom_ff;
   logic [RW-1:0]        radius_ff [NUM_CORNERS];
   logic                 settle_ff;
   logic                 csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff   <= '0;
         rect_top_ff    <= '0;
         rect_right_ff  <= '0;
         rect_bottom_ff <= '0;
         for (int i = 0; i < NUM_CORNERS; i++) begin
            radius_ff[i] <= '0;
         end
         settle_ff <= 1'b0;
      end else begin
         // Hold off new points in the cycle after a write so the derived registers catch up.
         settle_ff <= csr_write;
         if (csr_write) begin
            unique case (csr_index)
               CSR_RECT_LEFT:           rect_left_ff   <= csr_data;
               CSR_RECT_TOP:            rect_top_ff    <= csr_data;
               CSR_RECT_RIGHT:          rect_right_ff  <= csr_data;
               CSR_RECT_BOTTOM:         rect_bottom_ff <= csr_data;
               CSR_RADIUS_TOP_LEFT:     radius_ff[CORNER_TOP_LEFT]     <= csr_data[RW-1:0];
               CSR_RADIUS_TOP_RIGHT:    radius_ff[CORNER_TOP_RIGHT]    <= csr_data[RW-1:0];
               CSR_RADIUS_BOTTOM_LEFT:  radius_ff[CORNER_BOTTOM_LEFT]  <= csr_data[RW-1:0];
               CSR_RADIUS_BOTTOM_RIGHT: radius_ff[CORNER_BOTTOM_RIGHT] <= csr_data[RW-1:0];
               default: ;  // drop writes past the register list
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Derived geometry: clamped radii and arc centres, recomputed every cycle
   // ---------------------------------------------------------------------------
   logic signed [CW:0]   rect_w, rect_h, rect_min;
   logic [RW-1:0]        cmax;
   logic [RW-1:0]        rad_clamp [NUM_CORNERS];
   logic signed [CW:0]   ext_left, ext_top, ext_right, ext_bottom;

   logic [RW-1:0]        rad_ff   [NUM_CORNERS];
   logic signed [CW:0]   ctr_x_ff [NUM_CORNERS];
   logic signed [CW:0]   ctr_y_ff [NUM_CORNERS];

   always_comb begin
      ext_left   = {rect_left_ff[CW-1],   rect_left_ff};
      ext_top    = {rect_top_ff[CW-1],    rect_top_ff};
      ext_right  = {rect_right_ff[CW-1],  rect_right_ff};
      ext_bottom = {rect_bottom_ff[CW-1], rect_bottom_ff};
      rect_w     = ext_right - ext_left;
      rect_h     = ext_bottom - ext_top;
      rect_min   = (rect_w < rect_h) ? rect_w : rect_h;
      // An empty rectangle rejects every point, so its clamp value is moot.
      cmax       = rect_min[CW] ? '0 : rect_min[CW-1:1];
      for (int i = 0; i < NUM_CORNERS; i++) begin
         rad_clamp[i] = (radius_ff[i] < cmax) ? radius_ff[i] : cmax;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
         rad_ff[i] <= rad_clamp[i];
      end
      ctr_x_ff[CORNER_TOP_LEFT]     <= ext_left  + $signed({2'b00, rad_clamp[CORNER_TOP_LEFT]});
      ctr_y_ff[CORNER_TOP_LEFT]     <= ext_top   + $signed({2'b00, rad_clamp[CORNER_TOP_LEFT]});
      ctr_x_ff[CORNER_TOP_RIGHT]    <= ext_right - $signed({2'b00, rad_clamp[CORNER_TOP_RIGHT]});
      ctr_y_ff[CORNER_TOP_RIGHT]    <= ext_top   + $signed({2'b00, rad_clamp[CORNER_TOP_RIGHT]});
      ctr_x_ff[CORNER_BOTTOM_LEFT]  <= ext_left
                                       + $signed({2'b00, rad_clamp[CORNER_BOTTOM_LEFT]});
      ctr_y_ff[CORNER_BOTTOM_LEFT]  <= ext_bottom
                                       - $signed({2'b00, rad_clamp[CORNER_BOTTOM_LEFT]});
      ctr_x_ff[CORNER_BOTTOM_RIGHT] <= ext_right
                                       - $signed({2'b00, rad_clamp[CORNER_BOTTOM_RIGHT]});
      ctr_y_ff[CORNER_BOTTOM_RIGHT] <= ext_bottom
                                       - $signed({2'b00, rad_clamp[CORNER_BOTTOM_RIGHT]});
   end

   // ---------------------------------------------------------------------------
   // Pipeline handshake: a stage loads when it is empty or its word moves on
   // ---------------------------------------------------------------------------
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic ld0, ld1, ld2, ld3;
   logic req_take;

   assign ld3        = ~rsp_valid_ff | rsp_tready;
   assign ld2        = ~s2_valid_ff  | ld3;
   assign ld1        = ~s1_valid_ff  | ld2;
   assign ld0        = ~s0_valid_ff  | ld1;
   assign req_tready = ld0 & ~csr_valid & ~settle_ff;
   assign req_take   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld0) s0_valid_ff  <= req_take;
         if (ld1) s1_valid_ff  <= s0_valid_ff;
         if (ld2) s2_valid_ff  <= s1_valid_ff;
         if (ld3) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 0: input register
   // ---------------------------------------------------------------------------
   logic signed [CW-1:0] s0_x_ff, s0_y_ff;

   always_ff @(posedge clock) begin
      if (ld0 & req_take) begin
         s0_x_ff <= req_tdata[CW-1:0];
         s0_y_ff <= req_tdata[2*CW-1:CW];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: edge test, first corner square holding the point, offsets to its centre
   // ---------------------------------------------------------------------------
   logic signed [CW:0]   px, py;
   logic signed [CW+1:0] diff_x, diff_y;
   logic [CW+1:0]        abs_x, abs_y;
   logic                 in_rect, hit;
   logic [NUM_CORNERS-1:0] in_square;
   corner_type           sel;

   logic                 s1_inside_ff, s1_hit_ff;
   logic [RW-1:0]        s1_dx_ff, s1_dy_ff, s1_rad_ff;

   always_comb begin
      px = {s0_x_ff[CW-1], s0_x_ff};
      py = {s0_y_ff[CW-1], s0_y_ff};
      in_rect = (s0_x_ff > rect_left_ff) && (s0_x_ff < rect_right_ff)
             && (s0_y_ff > rect_top_ff)  && (s0_y_ff < rect_bottom_ff);
      in_square[CORNER_TOP_LEFT]     = (px < ctr_x_ff[CORNER_TOP_LEFT])
                                    && (py < ctr_y_ff[CORNER_TOP_LEFT]);
      in_square[CORNER_TOP_RIGHT]    = (px > ctr_x_ff[CORNER_TOP_RIGHT])
                                    && (py < ctr_y_ff[CORNER_TOP_RIGHT]);
      in_square[CORNER_BOTTOM_LEFT]  = (px < ctr_x_ff[CORNER_BOTTOM_LEFT])
                                    && (py > ctr_y_ff[CORNER_BOTTOM_LEFT]);
      in_square[CORNER_BOTTOM_RIGHT] = (px > ctr_x_ff[CORNER_BOTTOM_RIGHT])
                                    && (py > ctr_y_ff[CORNER_BOTTOM_RIGHT]);
      hit = |in_square;
      // Corners are checked in a fixed order; the first square that holds the point wins.
      priority if (in_square[CORNER_TOP_LEFT])    sel = CORNER_TOP_LEFT;
      else if (in_square[CORNER_TOP_RIGHT])       sel = CORNER_TOP_RIGHT;
      else if (in_square[CORNER_BOTTOM_LEFT])     sel = CORNER_BOTTOM_LEFT;
      else                                        sel = CORNER_BOTTOM_RIGHT;
      diff_x = {px[CW], px} - {ctr_x_ff[sel][CW], ctr_x_ff[sel]};
      diff_y = {py[CW], py} - {ctr_y_ff[sel][CW], ctr_y_ff[sel]};
      abs_x  = diff_x[CW+1] ? $unsigned(-diff_x) : $unsigned(diff_x);
      abs_y  = diff_y[CW+1] ? $unsigned(-diff_y) : $unsigned(diff_y);
   end

   always_ff @(posedge clock) begin
      if (ld1 & s0_valid_ff) begin
         s1_inside_ff <= in_rect;
         s1_hit_ff    <= hit;
         // Inside a corner square each offset is below the radius.
         s1_dx_ff     <= abs_x[RW-1:0];
         s1_dy_ff     <= abs_y[RW-1:0];
         s1_rad_ff    <= rad_ff[sel];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: squares
   // ---------------------------------------------------------------------------
   logic          s2_inside_ff, s2_hit_ff;
   logic [SW-1:0] s2_dx2_ff, s2_dy2_ff, s2_rr_ff;

   always_ff @(posedge clock) begin
      if (ld2 & s1_valid_ff) begin
         s2_inside_ff <= s1_inside_ff;
         s2_hit_ff    <= s1_hit_ff;
         s2_dx2_ff    <= s1_dx_ff  * s1_dx_ff;
         s2_dy2_ff    <= s1_dy_ff  * s1_dy_ff;
         s2_rr_ff     <= s1_rad_ff * s1_rad_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: distance compare into the output register
   // ---------------------------------------------------------------------------
   logic [SW:0] dist2;
   logic        inside_in;
   logic        inside_res_ff;

   always_comb begin
      dist2 = {1'b0, s2_dx2_ff} + {1'b0, s2_dy2_ff};
      if (!s2_inside_ff) begin
         inside_in = 1'b0;
      end else if (!s2_hit_ff) begin
         inside_in = 1'b1;
      end else begin
         inside_in = (dist2 <= {1'b0, s2_rr_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (ld3 & s2_valid_ff) begin
         inside_res_ff <= inside_in;
      end
   end

   assign rsp_tdata = {{(RSP_DATA_WIDTH-1){1'b0}}, inside_res_ff};

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   // No point may enter the cycle after a register write, while geometry settles.
   a_settle: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_take)
      else $error("point accepted before derived geometry settled");

   // A stalled stage 0 keeps its word.
   a_hold_s0: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && !ld1) |=> s0_valid_ff)
      else $error("stage 0 word lost under stall");

   // A point outside the rectangle edges always reports outside.
   a_outside: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && ld3 && !s2_inside_ff) |=> (rsp_tvalid && !rsp_tdata[0]))
      else $error("point outside rectangle reported inside");

endmodule
